[rtl/core/ptt_pkg.sv]
package ptt_pkg;

  localparam int unsigned NumSlotsDef = 16;
  localparam int unsigned SlotW = 4;
  localparam int unsigned TimeW = 64;
  localparam int unsigned CountW = 32;
  localparam int unsigned VisW = 5;

  typedef enum logic [2:0] {
    OP_ADD    = 3'd0,
    OP_REMOVE = 3'd1,
    OP_SET    = 3'd2,
    OP_GET    = 3'd3,
    OP_TICK   = 3'd4
  } opcode_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DONE
  } state_e;

  // Control broadcast from the sequencer to every cell
  typedef struct packed {
    logic                cmd_add;
    logic                cmd_remove;
    logic                cmd_set;
    logic                tick_start;
    logic                tick_end;
    logic [TimeW-1:0]    period;
    logic [TimeW-1:0]    due_time;
    logic [TimeW-1:0]    now_time;
  } cell_ctrl_t;

  // Token that travels along the chain of cells during a tick scan
  typedef struct packed {
    logic                act;
    logic [SlotW-1:0]    idx;
  } scan_tok_t;

endpackage

[rtl/core/ptt_cell.sv]
module ptt_cell (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  ptt_pkg::cell_ctrl_t  ctrl_i,
  input  logic                 sel_i,
  input  logic                 alloc_i,
  input  logic                 scan_i,
  output logic                 valid_o,
  output logic                 marked_o,
  output logic                 fire_o,
  output logic [ptt_pkg::CountW-1:0] count_o,
  output logic [ptt_pkg::TimeW-1:0]  period_o,
  output logic [ptt_pkg::TimeW-1:0]  due_o,
  output logic                 scan_o
);
  import ptt_pkg::*;

  logic valid_q, valid_d, marked_q, marked_d;
  logic [TimeW-1:0] period_q, period_d, due_q, due_d;
  logic [CountW-1:0] count_q, count_d;
  logic scan_q;
  logic hit;

  // Fire when the scan token sits here and due time is reached
  assign hit = scan_i && valid_q && (ctrl_i.now_time >= due_q);

  always_comb begin
    valid_d = valid_q;
    marked_d = marked_q;
    period_d = period_q;
    due_d = due_q;
    count_d = count_q;
    if (alloc_i) begin
      valid_d = 1'b1;
      marked_d = 1'b0;
      period_d = ctrl_i.period;
      due_d = ctrl_i.due_time;
      count_d = '0;
    end
    if (sel_i && ctrl_i.cmd_remove) marked_d = 1'b1;
    if (sel_i && ctrl_i.cmd_set) begin
      period_d = ctrl_i.period;
      if (ctrl_i.due_time != '0) due_d = ctrl_i.due_time;
    end
    if (hit) begin
      count_d = count_q + CountW'(1);
      due_d = due_q + period_q;
    end
    // Free marked slots at the end of the scan
    if (ctrl_i.tick_end && marked_q) begin
      valid_d = 1'b0;
      marked_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      marked_q <= 1'b0;
      scan_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
      marked_q <= marked_d;
      scan_q <= scan_i;
    end
  end

  always_ff @(posedge clk_i) begin
    period_q <= period_d;
    due_q <= due_d;
    count_q <= count_d;
  end

  assign valid_o = valid_q;
  assign marked_o = marked_q;
  assign fire_o = hit;
  assign count_o = count_q + CountW'(1);
  assign period_o = period_q;
  assign due_o = due_q;
  assign scan_o = scan_q;

endmodule

[rtl/core/periodic_timer_table.sv]
// Table of periodic timers built as a chain of slot cells. Add, remove, set,
// get and unused opcodes give their single reply strobe in the cycle right
// after the transaction is accepted; busy stays high through the ST_SCAN and
// ST_DONE states, so the next transaction can be accepted once the table is back
// in ST_IDLE. A tick passes a scan token down the chain one cell per cycle: fire
// strobes for due slots appear in index order in the ST_SCAN state, then the
// end-of-scan strobe with last_o high follows in the ST_DONE state.
// busy is high until the last strobe. The receiver cannot stall: every strobe
// must be taken in its cycle.
module periodic_timer_table #(
  parameter int unsigned NUM_SLOTS = ptt_pkg::NumSlotsDef
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start,
  output logic                         busy,
  input  logic [2:0]                   opcode_i,
  input  logic [ptt_pkg::SlotW-1:0]    slot_i,
  input  logic [ptt_pkg::TimeW-1:0]    period_i,
  input  logic [ptt_pkg::TimeW-1:0]    due_time_i,
  input  logic [ptt_pkg::TimeW-1:0]    now_time_i,
  output logic                         strobe_o,
  output logic                         kind_o,
  output logic                         ok_o,
  output logic [ptt_pkg::SlotW-1:0]    slot_out_o,
  output logic [ptt_pkg::CountW-1:0]   fire_count_o,
  output logic [ptt_pkg::TimeW-1:0]    period_out_o,
  output logic [ptt_pkg::TimeW-1:0]    due_out_o,
  output logic [ptt_pkg::VisW-1:0]     visited_o,
  output logic                         last_o
);
  import ptt_pkg::*;

  localparam int unsigned IdxW = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
  localparam int unsigned CntW = $clog2(NUM_SLOTS + 1);

  state_e state_q, state_d;
  logic [2:0] op_q;
  logic [SlotW-1:0] slot_q;
  logic [TimeW-1:0] per_q, due_q, now_q;
  logic [CntW-1:0] step_q, step_d;
  logic [VisW-1:0] vis_q, vis_d;
  logic [VisW-1:0] mtot_q, mtot_d;

  cell_ctrl_t ctrl;
  logic [NUM_SLOTS-1:0] valid, marked, fire, sel, alloc, scan_in, scan_out;
  logic [CountW-1:0] cnt [NUM_SLOTS];
  logic [TimeW-1:0] cper [NUM_SLOTS];
  logic [TimeW-1:0] cdue [NUM_SLOTS];

  logic accept, found, any_free;
  logic [IdxW-1:0] free_idx, scan_idx;
  logic in_range;
  logic scan_active;

  assign accept = start && !busy;

  // Capture the transaction
  always_ff @(posedge clk_i) begin
    if (accept) begin
      op_q <= opcode_i;
      slot_q <= slot_i;
      per_q <= period_i;
      due_q <= due_time_i;
      now_q <= now_time_i;
    end
  end

  // Lowest free slot
  always_comb begin
    any_free = 1'b0;
    free_idx = '0;
    for (int i = NUM_SLOTS - 1; i >= 0; i--) begin
      if (!valid[i]) begin
        any_free = 1'b1;
        free_idx = IdxW'(i);
      end
    end
  end

  assign in_range = (32'(slot_q) < NUM_SLOTS);
  assign found = in_range && valid[IdxW'(slot_q)];
  assign scan_idx = IdxW'(step_q);
  assign scan_active = (state_q == ST_SCAN) && (op_q == OP_TICK);

  // Next state
  always_comb begin
    state_d = state_q;
    step_d = step_q;
    unique case (state_q)
      ST_IDLE: if (accept) begin
        state_d = ST_SCAN;
        step_d = '0;
      end
      ST_SCAN: begin
        if (op_q != OP_TICK || step_q == CntW'(NUM_SLOTS - 1)) state_d = ST_DONE;
        else step_d = step_q + CntW'(1);
      end
      ST_DONE: state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  // Broadcast control to the cells
  always_comb begin
    ctrl.cmd_add = (state_q == ST_SCAN) && (op_q == OP_ADD) && any_free;
    ctrl.cmd_remove = (state_q == ST_SCAN) && (op_q == OP_REMOVE) && found;
    ctrl.cmd_set = (state_q == ST_SCAN) && (op_q == OP_SET) && found;
    ctrl.tick_start = scan_active && (step_q == '0);
    ctrl.tick_end = (state_q == ST_DONE) && (op_q == OP_TICK) && (mtot_q != '0);
    ctrl.period = per_q;
    ctrl.due_time = due_q;
    ctrl.now_time = now_q;
  end

  for (genvar g = 0; g < NUM_SLOTS; g++) begin : g_cell
    assign sel[g] = in_range && (IdxW'(slot_q) == IdxW'(g));
    assign alloc[g] = ctrl.cmd_add && (free_idx == IdxW'(g));
    if (g == 0) begin : g_head
      assign scan_in[g] = ctrl.tick_start;
    end else begin : g_link
      assign scan_in[g] = scan_out[g-1];
    end
    ptt_cell u_cell (
      .clk_i, .rst_ni, .ctrl_i(ctrl), .sel_i(sel[g]), .alloc_i(alloc[g]),
      .scan_i(scan_in[g] && scan_active), .valid_o(valid[g]), .marked_o(marked[g]),
      .fire_o(fire[g]), .count_o(cnt[g]), .period_o(cper[g]), .due_o(cdue[g]),
      .scan_o(scan_out[g])
    );
  end

  // Visited count and marked total
  always_comb begin
    vis_d = vis_q;
    mtot_d = mtot_q;
    if (accept) vis_d = '0;
    else if (scan_active && valid[scan_idx]) vis_d = vis_q + VisW'(1);
    if (ctrl.cmd_remove && !marked[IdxW'(slot_q)]) mtot_d = mtot_q + VisW'(1);
    if ((state_q == ST_DONE) && (op_q == OP_TICK)) mtot_d = '0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      step_q <= '0;
      vis_q <= '0;
      mtot_q <= '0;
    end else begin
      state_q <= state_d;
      step_q <= step_d;
      vis_q <= vis_d;
      mtot_q <= mtot_d;
    end
  end

  assign busy = (state_q != ST_IDLE);

  // Drive result ports
  always_comb begin
    strobe_o = 1'b0;
    kind_o = 1'b1;
    ok_o = 1'b0;
    slot_out_o = '0;
    fire_count_o = '0;
    period_out_o = '0;
    due_out_o = '0;
    visited_o = '0;
    last_o = 1'b0;
    if (scan_active) begin
      if (fire[scan_idx]) begin
        strobe_o = 1'b1;
        kind_o = 1'b0;
        ok_o = 1'b1;
        slot_out_o = SlotW'(scan_idx);
        fire_count_o = cnt[scan_idx];
      end
    end else if (state_q == ST_SCAN) begin
      strobe_o = 1'b1;
      last_o = 1'b1;
      unique case (op_q)
        OP_ADD: begin
          ok_o = any_free;
          slot_out_o = any_free ? SlotW'(free_idx) : '0;
        end
        OP_REMOVE, OP_SET: ok_o = found;
        OP_GET: begin
          ok_o = found;
          period_out_o = found ? cper[IdxW'(slot_q)] : '0;
          due_out_o = found ? cdue[IdxW'(slot_q)] : '0;
        end
        default: ok_o = 1'b0;
      endcase
    end else if ((state_q == ST_DONE) && (op_q == OP_TICK)) begin
      strobe_o = 1'b1;
      ok_o = 1'b1;
      visited_o = vis_q;
      last_o = 1'b1;
    end
  end

  // Checks
  a_no_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy |-> !accept) else $error("accept while busy");
  a_last_strobe: assert property (@(posedge clk_i) disable iff (!rst_ni)
    last_o |-> strobe_o) else $error("last without strobe");
  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DONE) |=> (state_q == ST_IDLE)) else $error("done stuck");
  a_fire_kind: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (strobe_o && !kind_o) |-> (scan_active && !last_o)) else $error("stray fire");

endmodule
